FILE: sv/pmpred_pkg.sv
// ----------------------------------------------------------------------------
// pmpred_pkg
// Shared types and constants for the protection region encode/decode block.
// ----------------------------------------------------------------------------
package pmpred_pkg;

  localparam int ENTRY_COUNT = 16;
  localparam int XLEN_BITS   = 64;
  localparam int GRAIN_SHIFT = 2;
  localparam int IDX_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int SHAMT_W     = $clog2(XLEN_BITS);
  localparam int LOG_W       = 7;
  localparam int CHUNK_W     = 16;
  localparam int CHUNK_LOG_W = $clog2(CHUNK_W);

  localparam logic [7:0] MODE_FIELD = 8'h18;
  localparam logic [7:0] MODE_NA4   = 8'h10;
  localparam logic [7:0] MODE_NAPOT = 8'h18;

  typedef enum logic {
    ACT_SET = 1'b0,
    ACT_GET = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COUNT,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic                   en;
    logic [IDX_W-1:0]       idx;
    logic [7:0]             cfg;
    logic [XLEN_BITS-1:0]   addr;
  } tbl_wr_t;

  typedef struct packed {
    logic             done;
    logic [LOG_W-1:0] count;
  } cnt_stat_t;

endpackage

FILE: sv/pmp_region_encode_decode.sv
// ----------------------------------------------------------------------------
// pmp_region_encode_decode
// Encodes and decodes protection table entries (NA4 / NAPOT address words).
// ----------------------------------------------------------------------------
// sequence: set, invalid and non-NAPOT get go from EXEC to RESP, which raises done_o;
//   a NAPOT get of a word that is not all ones passes through COUNT between them, by 16-bit chunk
// throughput: one item at a time, start is taken again the cycle after done_o
// reset: all entries clear to zero config (off) and zero address
// the result is shown for one cycle on done_o and cannot be stalled
module pmp_region_encode_decode (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        action_i,
  input  logic [5:0]  entry_i,
  input  logic [7:0]  permissions_i,
  input  logic [63:0] region_base_i,
  input  logic [6:0]  size_exponent_i,
  output logic        done_o,
  output logic        status_o,
  output logic [7:0]  config_byte_o,
  output logic [63:0] decoded_base_o,
  output logic [63:0] decoded_size_o
);
  import pmpred_pkg::*;

  state_e state_q, state_d;

  logic                 action_q;
  logic [5:0]           entry_q;
  logic [7:0]           perm_q;
  logic [XLEN_BITS-1:0] base_q;
  logic [6:0]           lg_q;

  logic                 status_q, status_d;
  logic [7:0]           cfg_q, cfg_d;
  logic [XLEN_BITS-1:0] dbase_q, dbase_d;
  logic [XLEN_BITS-1:0] dsize_q, dsize_d;

  tbl_wr_t              tbl_wr;
  logic [7:0]           rd_cfg;
  logic [XLEN_BITS-1:0] rd_addr;
  logic                 cnt_load;
  cnt_stat_t            cnt_stat;

  logic                 idx_ok;
  logic                 lg_ok;
  logic                 is_napot;
  logic                 all_ones;
  logic                 need_cnt;
  logic                 accept;
  logic                 latch_res;
  logic [SHAMT_W-1:0]   enc_sh;
  logic [XLEN_BITS-1:0] enc_low;
  logic [XLEN_BITS-1:0] enc_word;
  logic [7:0]           enc_cfg;
  logic [XLEN_BITS-1:0] keep;
  logic [LOG_W-1:0]     dlog;

  pmpred_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (tbl_wr),
    .rd_idx_i  (entry_q[IDX_W-1:0]),
    .rd_cfg_o  (rd_cfg),
    .rd_addr_o (rd_addr)
  );

  pmpred_ones_cnt u_cnt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (cnt_load),
    .word_i (rd_addr),
    .stat_o (cnt_stat)
  );

  // argument checks and mode of the stored entry
  always_comb begin
    idx_ok   = 7'(entry_q) < 7'(ENTRY_COUNT);
    lg_ok    = (lg_q >= 7'(GRAIN_SHIFT)) && (lg_q <= 7'(XLEN_BITS));
    is_napot = (rd_cfg & MODE_FIELD) == MODE_NAPOT;
    all_ones = &rd_addr;
    need_cnt = idx_ok && (action_e'(action_q) == ACT_GET) && is_napot && !all_ones;
  end

  // set encode
  always_comb begin
    enc_sh  = SHAMT_W'(lg_q - 7'(GRAIN_SHIFT));
    enc_low = (XLEN_BITS'(1) << enc_sh) - XLEN_BITS'(1);
    if (lg_q == 7'(GRAIN_SHIFT)) begin
      enc_cfg  = perm_q | MODE_NA4;
      enc_word = base_q >> GRAIN_SHIFT;
    end else if (lg_q == 7'(XLEN_BITS)) begin
      enc_cfg  = perm_q | MODE_NAPOT;
      enc_word = '1;
    end else begin
      enc_cfg  = perm_q | MODE_NAPOT;
      enc_word = ((base_q >> GRAIN_SHIFT) & ~enc_low) | (enc_low >> 1);
    end
    tbl_wr.en   = (state_q == ST_EXEC) && idx_ok && lg_ok &&
                  (action_e'(action_q) == ACT_SET);
    tbl_wr.idx  = entry_q[IDX_W-1:0];
    tbl_wr.cfg  = enc_cfg;
    tbl_wr.addr = enc_word;
  end

  // result select
  always_comb begin
    keep     = ~((XLEN_BITS'(1) << cnt_stat.count[SHAMT_W-1:0]) - XLEN_BITS'(1));
    dlog     = cnt_stat.count + LOG_W'(GRAIN_SHIFT + 1);
    status_d = 1'b0;
    cfg_d    = '0;
    dbase_d  = '0;
    dsize_d  = '0;
    if (!idx_ok) begin
      status_d = 1'b1;
    end else if (action_e'(action_q) == ACT_SET) begin
      status_d = !lg_ok;
    end else begin
      cfg_d = rd_cfg;
      if (!is_napot) begin
        dbase_d = rd_addr << GRAIN_SHIFT;
        dsize_d = XLEN_BITS'(1) << GRAIN_SHIFT;
      end else if (all_ones) begin
        dbase_d = '0;
        dsize_d = '0;
      end else begin
        dbase_d = (rd_addr & keep) << GRAIN_SHIFT;
        dsize_d = (dlog < LOG_W'(XLEN_BITS)) ? (XLEN_BITS'(1) << dlog[SHAMT_W-1:0]) : '0;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = need_cnt ? ST_COUNT : ST_RESP;
      end
      ST_COUNT: begin
        if (cnt_stat.done) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    accept    = 1'b0;
    cnt_load  = 1'b0;
    latch_res = 1'b0;
    busy_o    = 1'b1;
    done_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        accept = start_i;
      end
      ST_EXEC: begin
        cnt_load  = need_cnt;
        latch_res = !need_cnt;
      end
      ST_COUNT: begin
        latch_res = cnt_stat.done;
      end
      ST_RESP: begin
        done_o = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_i;
      entry_q  <= entry_i;
      perm_q   <= permissions_i;
      base_q   <= region_base_i;
      lg_q     <= size_exponent_i;
    end
    if (latch_res) begin
      status_q <= status_d;
      cfg_q    <= cfg_d;
      dbase_q  <= dbase_d;
      dsize_q  <= dsize_d;
    end
  end

  assign status_o       = status_q;
  assign config_byte_o  = cfg_q;
  assign decoded_base_o = dbase_q;
  assign decoded_size_o = dsize_q;

endmodule

FILE: sv/pmpred_table.sv
// ----------------------------------------------------------------------------
// pmpred_table
// Per-entry config bytes and address words, cleared at reset.
// ----------------------------------------------------------------------------
module pmpred_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pmpred_pkg::tbl_wr_t           wr_i,
  input  logic [pmpred_pkg::IDX_W-1:0]  rd_idx_i,
  output logic [7:0]                    rd_cfg_o,
  output logic [pmpred_pkg::XLEN_BITS-1:0] rd_addr_o
);
  import pmpred_pkg::*;

  logic [7:0]           cfg_q  [ENTRY_COUNT];
  logic [XLEN_BITS-1:0] addr_q [ENTRY_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        cfg_q[i]  <= '0;
        addr_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      cfg_q[wr_i.idx]  <= wr_i.cfg;
      addr_q[wr_i.idx] <= wr_i.addr;
    end
  end

  assign rd_cfg_o  = cfg_q[rd_idx_i];
  assign rd_addr_o = addr_q[rd_idx_i];

endmodule

FILE: sv/pmpred_ones_cnt.sv
// ----------------------------------------------------------------------------
// pmpred_ones_cnt
// Trailing-ones counter, one chunk of the address word per cycle.
// ----------------------------------------------------------------------------
module pmpred_ones_cnt (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  logic [pmpred_pkg::XLEN_BITS-1:0] word_i,
  output pmpred_pkg::cnt_stat_t            stat_o
);
  import pmpred_pkg::*;

  logic [XLEN_BITS-1:0]   sh_q, sh_d;
  logic [LOG_W-1:0]       cnt_q, cnt_d;
  logic                   run_q, run_d;
  logic [CHUNK_W-1:0]     chunk;
  logic                   full;
  logic [CHUNK_LOG_W-1:0] tz;

  always_comb begin
    chunk = sh_q[CHUNK_W-1:0];
    full  = &chunk;
    tz    = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      if (!chunk[i]) begin
        tz = CHUNK_LOG_W'(i);
      end
    end
  end

  always_comb begin
    sh_d  = sh_q;
    cnt_d = cnt_q;
    run_d = run_q;
    if (load_i) begin
      sh_d  = word_i;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (full) begin
        sh_d  = sh_q >> CHUNK_W;
        cnt_d = cnt_q + LOG_W'(CHUNK_W);
      end else begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  assign stat_o.done  = run_q && !full;
  assign stat_o.count = cnt_q + LOG_W'(tz);

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the protection region encode/decode block. Set and
// get commands are driven with random sender gaps; a scoreboard keeps its own
// copy of the entry table, predicts each transfer and checks every strobed
// result field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  import pmpred_pkg::*;

  typedef struct packed {
    logic        status;
    logic [7:0]  cfg;
    logic [63:0] base;
    logic [63:0] size;
  } region_result_t;

  class pmp_table_scoreboard;
    logic [7:0]     entry_cfg [ENTRY_COUNT];
    logic [63:0]    entry_addr[ENTRY_COUNT];
    region_result_t pending_results[$];
    int             mismatches;

    function new();
      foreach (entry_cfg[i]) begin
        entry_cfg[i]  = 8'h00;
        entry_addr[i] = 64'h0;
      end
      mismatches = 0;
    endfunction

    function region_result_t encode_or_decode(action_e act, logic [5:0] idx,
                                              logic [7:0] perm, logic [63:0] base,
                                              logic [6:0] lg);
      region_result_t r;
      logic [7:0]     cfg;
      logic [63:0]    low;
      logic [63:0]    word;
      logic [63:0]    keep;
      int             t;
      int             dlog;
      r = '0;
      r.status = 1'b1;
      if (idx >= ENTRY_COUNT) return r;
      if (act == ACT_SET) begin
        if (lg > XLEN_BITS || lg < GRAIN_SHIFT) return r;
        if (lg == GRAIN_SHIFT) begin
          cfg  = perm | MODE_NA4;
          word = base >> GRAIN_SHIFT;
        end else begin
          cfg = perm | MODE_NAPOT;
          if (lg == XLEN_BITS) begin
            word = '1;
          end else begin
            low  = (64'd1 << (lg - GRAIN_SHIFT)) - 64'd1;
            word = ((base >> GRAIN_SHIFT) & ~low) | (low >> 1);
          end
        end
        entry_cfg[idx]  = cfg;
        entry_addr[idx] = word;
        r.status = 1'b0;
        return r;
      end
      cfg  = entry_cfg[idx];
      word = entry_addr[idx];
      if ((cfg & MODE_FIELD) == MODE_NAPOT) begin
        if (word == '1) begin
          r.base = 64'h0;
          dlog   = XLEN_BITS;
        end else begin
          t = 0;
          while (t < 64 && word[t]) t++;
          keep   = ~((64'd1 << t) - 64'd1);
          r.base = (word & keep) << GRAIN_SHIFT;
          dlog   = t + GRAIN_SHIFT + 1;
        end
      end else begin
        r.base = word << GRAIN_SHIFT;
        dlog   = GRAIN_SHIFT;
      end
      r.status = 1'b0;
      r.cfg    = cfg;
      r.size   = (dlog < XLEN_BITS) ? (64'd1 << dlog) : 64'd0;
      return r;
    endfunction

    function void note_transfer(action_e act, logic [5:0] idx, logic [7:0] perm,
                                logic [63:0] base, logic [6:0] lg);
      pending_results.push_back(encode_or_decode(act, idx, perm, base, lg));
    endfunction

    function void check_transfer(region_result_t got);
      region_result_t exp_r;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("error: result with nothing pending: st=%0d cfg=%02h base=%016h size=%016h",
                   got.status, got.cfg, got.base, got.size);
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.status !== exp_r.status || got.cfg !== exp_r.cfg ||
          got.base !== exp_r.base || got.size !== exp_r.size) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("error: exp st=%0d cfg=%02h base=%016h size=%016h",
                   exp_r.status, exp_r.cfg, exp_r.base, exp_r.size);
          $display("       got st=%0d cfg=%02h base=%016h size=%016h",
                   got.status, got.cfg, got.base, got.size);
        end
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        start_i         = 1'b0;
  logic        action_i        = 1'b0;
  logic [5:0]  entry_i         = '0;
  logic [7:0]  permissions_i   = '0;
  logic [63:0] region_base_i   = '0;
  logic [6:0]  size_exponent_i = '0;
  logic        busy_o;
  logic        done_o;
  logic        status_o;
  logic [7:0]  config_byte_o;
  logic [63:0] decoded_base_o;
  logic [63:0] decoded_size_o;

  pmp_table_scoreboard sb;

  pmp_region_encode_decode u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .action_i        (action_i),
    .entry_i         (entry_i),
    .permissions_i   (permissions_i),
    .region_base_i   (region_base_i),
    .size_exponent_i (size_exponent_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .config_byte_o   (config_byte_o),
    .decoded_base_o  (decoded_base_o),
    .decoded_size_o  (decoded_size_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o)
        sb.check_transfer({status_o, config_byte_o, decoded_base_o, decoded_size_o});
      if (start_i && !busy_o)
        sb.note_transfer(action_e'(action_i), entry_i, permissions_i, region_base_i,
                         size_exponent_i);
    end
  end

  // called at a rising edge; returns at the edge where the transfer happens
  task automatic send_item(action_e act, logic [5:0] idx, logic [7:0] perm,
                           logic [63:0] base, logic [6:0] lg);
    start_i         <= 1'b1;
    action_i        <= act;
    entry_i         <= idx;
    permissions_i   <= perm;
    region_base_i   <= base;
    size_exponent_i <= lg;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic idle_burst(int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic logic [6:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return 7'd2;
      1:       return 7'd64;
      2:       return 7'd63;
      3:       return 7'd3;
      default: return 7'($urandom_range(2, 64));
    endcase
  endfunction

  function automatic logic [63:0] pick_base();
    case ($urandom_range(0, 15))
      0:       return '1;
      1:       return '0;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  initial begin
    int          n_items;
    int          kind;
    bit          gaps_on;
    logic [6:0]  lg;
    n_items = 1600;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(ACT_GET, 6'd0,  8'h00, 64'h0, 7'd0);
    send_item(ACT_SET, 6'd0,  8'h01, 64'h1234_5678_9abc_def0, 7'd2);
    send_item(ACT_GET, 6'd0,  8'h00, 64'h0, 7'd0);
    send_item(ACT_SET, 6'd1,  8'h03, 64'hffff_ffff_ffff_ffff, 7'd3);
    send_item(ACT_GET, 6'd1,  8'hff, 64'hffff_ffff_ffff_ffff, 7'd127);
    send_item(ACT_SET, 6'd2,  8'h07, 64'hdead_beef_cafe_f00d, 7'd64);
    send_item(ACT_GET, 6'd2,  8'h00, 64'h0, 7'd0);
    send_item(ACT_SET, 6'd3,  8'h80, 64'h8000_0000_0000_0000, 7'd63);
    send_item(ACT_GET, 6'd3,  8'h00, 64'h0, 7'd0);
    send_item(ACT_SET, 6'd15, 8'h08, 64'hffff_ffff_ffff_ffff, 7'd2);
    send_item(ACT_GET, 6'd15, 8'h00, 64'h0, 7'd0);
    send_item(ACT_SET, 6'd4,  8'hff, 64'h0, 7'd2);
    send_item(ACT_GET, 6'd4,  8'h00, 64'h0, 7'd0);
    send_item(ACT_SET, 6'd5,  8'h18, 64'h0000_0000_0000_0c00, 7'd10);
    send_item(ACT_GET, 6'd5,  8'h00, 64'h0, 7'd0);
    send_item(ACT_SET, 6'd6,  8'h07, 64'h1000, 7'd0);
    send_item(ACT_SET, 6'd6,  8'h07, 64'h1000, 7'd1);
    send_item(ACT_SET, 6'd6,  8'h07, 64'h1000, 7'd65);
    send_item(ACT_SET, 6'd6,  8'h07, 64'h1000, 7'd127);
    send_item(ACT_GET, 6'd6,  8'h00, 64'h0, 7'd0);
    send_item(ACT_SET, 6'd16, 8'h07, 64'h1000, 7'd10);
    send_item(ACT_GET, 6'd63, 8'hff, 64'hffff_ffff_ffff_ffff, 7'd127);
    send_item(ACT_GET, 6'd1,  8'h00, 64'h0, 7'd0);

    gaps_on = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (i == n_items / 2) drain();
      if (gaps_on && i < n_items - 200 && $urandom_range(0, 3) == 0)
        idle_burst($urandom_range(1, 7));
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        send_item(ACT_SET, 6'($urandom_range(0, ENTRY_COUNT - 1)), 8'($urandom()),
                  pick_base(), pick_size());
      end else if (kind < 88) begin
        send_item(ACT_GET, 6'($urandom_range(0, ENTRY_COUNT - 1)), 8'($urandom()),
                  {$urandom(), $urandom()}, 7'($urandom()));
      end else if (kind < 94) begin
        send_item(action_e'($urandom_range(0, 1)), 6'($urandom_range(ENTRY_COUNT, 63)),
                  8'($urandom()), {$urandom(), $urandom()}, 7'($urandom()));
      end else begin
        lg = ($urandom_range(0, 1) != 0) ? 7'($urandom_range(0, 1)) :
                                           7'($urandom_range(65, 127));
        send_item(ACT_SET, 6'($urandom_range(0, ENTRY_COUNT - 1)), 8'($urandom()),
                  {$urandom(), $urandom()}, lg);
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: pmp_region_encode_decode.f
sv/pmpred_pkg.sv
sv/pmpred_table.sv
sv/pmpred_ones_cnt.sv
sv/pmp_region_encode_decode.sv
dv/testbench.sv
